### rtl/hsh_pkg.sv
// Shared types, constants and the ARX round function for the HalfSipHash unit.
package hsh_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 8;
    localparam int CNT_W  = 3;

    localparam logic [WORD_W-1:0] INIT_C2   = 32'h6c796765;
    localparam logic [WORD_W-1:0] INIT_C3   = 32'h74656462;
    localparam logic [LEN_W-1:0]  FINAL_XOR = 8'hff;
    localparam int                LEN_SHIFT = 24;

    localparam logic [CNT_W-1:0]  FULL_COUNT = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [WORD_W-1:0] hsh_word_t;

    // Chaining words, index 0 is v0.
    typedef logic [3:0][WORD_W-1:0] hsh_state_t;

    // One classified word. init loads the chaining words from the key first,
    // full compresses msg_word, fin compresses final_block and finalizes.
    typedef struct packed {
        logic      init;
        logic      full;
        logic      fin;
        hsh_word_t msg_word;
        hsh_word_t final_block;
    } hsh_cmd_t;

    function automatic hsh_word_t hsh_rotl(input hsh_word_t x, input int unsigned r);
        hsh_word_t res;
        res = (x << r) | (x >> (WORD_W - r));
        return res;
    endfunction

    function automatic hsh_state_t hsh_round(input hsh_state_t v);
        hsh_word_t  a;
        hsh_word_t  b;
        hsh_word_t  c;
        hsh_word_t  d;
        hsh_state_t res;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; b = hsh_rotl(b, 5);  b = b ^ a; a = hsh_rotl(a, 16);
        c = c + d; d = hsh_rotl(d, 8);  d = d ^ c;
        a = a + d; d = hsh_rotl(d, 7);  d = d ^ a;
        c = c + b; b = hsh_rotl(b, 13); b = b ^ c; c = hsh_rotl(c, 16);
        res[0] = a;
        res[1] = b;
        res[2] = c;
        res[3] = d;
        return res;
    endfunction

endpackage

### rtl/hsh_front.sv
// Front end: accepts message words, tracks length and builds hash commands.
module hsh_front import hsh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_message_word,
    input  logic [CNT_W-1:0]  s_byte_count,
    input  logic              s_last_word,
    input  logic              q_full,
    output logic              q_push,
    output hsh_cmd_t          q_cmd
);

    logic             in_msg_reg;
    logic             in_msg_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_base;
    logic [CNT_W-1:0] count_c;
    logic [1:0]       tail;
    hsh_word_t        tail_mask;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        // Counts above four mean four.
        count_c  = (s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;
        len_base = in_msg_reg ? len_reg : '0;
        tail     = (count_c == FULL_COUNT) ? 2'd0 : count_c[1:0];

        case (tail)
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase

        q_cmd.init     = !in_msg_reg;
        q_cmd.msg_word = s_message_word;
        if (s_last_word) begin
            len_next    = len_base + LEN_W'(count_c);
            q_cmd.full  = (count_c == FULL_COUNT);
            q_cmd.fin   = 1'b1;
            in_msg_next = 1'b0;
        end else begin
            len_next    = len_base + LEN_W'(FULL_COUNT);
            q_cmd.full  = 1'b1;
            q_cmd.fin   = 1'b0;
            in_msg_next = 1'b1;
        end
        q_cmd.final_block = {len_next, {LEN_SHIFT{1'b0}}} | (s_message_word & tail_mask);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            len_reg    <= '0;
        end else if (q_push) begin
            in_msg_reg <= in_msg_next;
            len_reg    <= len_next;
        end
    end

endmodule

### rtl/hsh_queue.sv
// Small command queue that decouples the front end from the round engine.
module hsh_queue import hsh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  hsh_cmd_t push_cmd,
    output logic     full,
    output logic     valid,
    input  logic     pop,
    output hsh_cmd_t pop_cmd
);

    hsh_cmd_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     cnt_reg;
    logic [Q_AW:0]     cnt_next;

    assign full    = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/hsh_back.sv
// Round engine: one ARX round per cycle unless a held result stalls, compression, finalization and result register.
module hsh_back import hsh_pkg::*; #(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WORD_W-1:0] key_low,
    input  logic [WORD_W-1:0] key_high,
    input  logic              cmd_valid,
    input  hsh_cmd_t          cmd,
    output logic              cmd_pop,
    output logic              hash_valid,
    input  logic              hash_ready,
    output logic [WORD_W-1:0] hash_value
);

    localparam int MAX_ROUNDS = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS
                                                                  : FINAL_ROUNDS;
    localparam int RND_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam logic [RND_W-1:0] C_LAST = RND_W'(COMPRESS_ROUNDS - 1);
    localparam logic [RND_W-1:0] F_LAST = RND_W'(FINAL_ROUNDS - 1);

    // Phases of one command.
    localparam logic [1:0] SEG_MSG = 2'd0;
    localparam logic [1:0] SEG_BLK = 2'd1;
    localparam logic [1:0] SEG_FIN = 2'd2;

    logic             busy_reg,  busy_next;
    logic [1:0]       seg_reg,   seg_next;
    logic [RND_W-1:0] rnd_reg,   rnd_next;
    logic             hvalid_reg, hvalid_next;
    hsh_state_t       v_reg,     v_next;
    hsh_cmd_t         cmd_reg,   cmd_next;
    hsh_word_t        hash_reg,  hash_next;

    hsh_cmd_t         cur_cmd;
    logic [1:0]       cur_seg;
    logic [1:0]       adv_seg;
    logic [RND_W-1:0] cur_rnd;
    logic             active;
    logic             is_comp;
    logic             seg_last;
    logic             done;
    logic             emit;
    logic             stall;
    logic             step;
    hsh_word_t        blk_word;
    hsh_state_t       src;
    hsh_state_t       pre;
    hsh_state_t       post;

    assign hash_valid = hvalid_reg;
    assign hash_value = hash_reg;

    always_comb begin
        cur_cmd  = busy_reg ? cmd_reg : cmd;
        cur_seg  = busy_reg ? seg_reg : (cmd.full ? SEG_MSG : SEG_BLK);
        cur_rnd  = busy_reg ? rnd_reg : '0;
        active   = busy_reg || cmd_valid;
        is_comp  = (cur_seg != SEG_FIN);
        seg_last = is_comp ? (cur_rnd == C_LAST) : (cur_rnd == F_LAST);
        blk_word = (cur_seg == SEG_MSG) ? cur_cmd.msg_word : cur_cmd.final_block;
        done     = seg_last && ((cur_seg == SEG_FIN) ||
                                ((cur_seg == SEG_MSG) && !cur_cmd.fin));
        emit     = seg_last && (cur_seg == SEG_FIN);
        stall    = emit && hvalid_reg && !hash_ready;
        step     = active && !stall;
        cmd_pop  = step && !busy_reg;

        case (cur_seg)
            SEG_MSG: adv_seg = SEG_BLK;
            default: adv_seg = SEG_FIN;
        endcase

        // A new message starts from the key and the fixed constants.
        if (!busy_reg && cmd.init) begin
            src[0] = key_low;
            src[1] = key_high;
            src[2] = key_low ^ INIT_C2;
            src[3] = key_high ^ INIT_C3;
        end else begin
            src = v_reg;
        end

        pre = src;
        if (cur_rnd == '0) begin
            if (is_comp) begin
                pre[3] = src[3] ^ blk_word;
            end else begin
                pre[2] = src[2] ^ WORD_W'(FINAL_XOR);
            end
        end

        post = hsh_round(pre);
        if (seg_last && is_comp) begin
            post[0] = post[0] ^ blk_word;
        end

        busy_next = busy_reg;
        seg_next  = seg_reg;
        rnd_next  = rnd_reg;
        v_next    = v_reg;
        cmd_next  = cmd_reg;
        hash_next = hash_reg;
        if (step) begin
            v_next   = post;
            cmd_next = cur_cmd;
            if (seg_last) begin
                busy_next = !done;
                seg_next  = adv_seg;
                rnd_next  = '0;
            end else begin
                busy_next = 1'b1;
                seg_next  = cur_seg;
                rnd_next  = cur_rnd + 1'b1;
            end
            if (emit) begin
                hash_next = post[1] ^ post[3];
            end
        end
        hvalid_next = (hvalid_reg && !hash_ready) || (step && emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            seg_reg    <= SEG_MSG;
            rnd_reg    <= '0;
            hvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            seg_reg    <= seg_next;
            rnd_reg    <= rnd_next;
            hvalid_reg <= hvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        cmd_reg  <= cmd_next;
        hash_reg <= hash_next;
    end

endmodule

### rtl/halfsiphash_2_4_32bit_unit.sv
// Top level of the keyed HalfSipHash-2-4 unit with 32-bit output.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_message_word, s_byte_count, s_last_word
//  m_        out        m_valid / m_ready   m_hash_value
//  cfg_      in         cfg_write_en        cfg_index, cfg_write_data
//
// A non-last word runs COMPRESS_ROUNDS rounds (two by default) on the
// single ARX round unit in the back end, which does one round per cycle
// while no held result stalls it. A last word runs COMPRESS_ROUNDS +
// FINAL_ROUNDS rounds, or 2*COMPRESS_ROUNDS + FINAL_ROUNDS when it carries four bytes.
// Reset is synchronous and active low; it empties the queue and drops any
// pending result, and the key registers return to zero.
// A stalled result only blocks the round unit at the very end of the next
// finalization; the front end keeps taking words until the queue fills.
module halfsiphash_2_4_32bit_unit import hsh_pkg::*; #(
    parameter int COMPRESS_ROUNDS = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_write_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_message_word,
    input  logic [CNT_W-1:0]     s_byte_count,
    input  logic                 s_last_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_hash_value
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;

    logic     q_full;
    logic     q_push;
    hsh_cmd_t q_in_cmd;
    logic     q_valid;
    logic     q_pop;
    hsh_cmd_t q_out_cmd;

    // The key is read by the back end when a message's first word starts,
    // so a key written after that first word has started applies to the next one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_write_en) begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_write_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_write_data;
                default: ;
            endcase
        end
    end

    // The front end classifies each word and builds the final length block.
    hsh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last_word    (s_last_word),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_in_cmd)
    );

    hsh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_cmd  (q_out_cmd)
    );

    // The back end runs the rounds and holds the result in its own register.
    hsh_back #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .cmd_valid  (q_valid),
        .cmd        (q_out_cmd),
        .cmd_pop    (q_pop),
        .hash_valid (m_valid),
        .hash_ready (m_ready),
        .hash_value (m_hash_value)
    );

endmodule

### rtl/hsh_checker.sv
// Port-level checker for the HalfSipHash unit and its bind statement.
module hsh_checker import hsh_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [WORD_W-1:0] m_hash_value
);

    // A held result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("result changed or dropped while stalled");

    // Reset drops any pending result.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result present right after reset");

    // A result cannot appear in the cycle after the first cycle out of reset.
    assert property (@(posedge aclk) !aresetn ##1 aresetn |=> !m_valid)
        else $error("result appeared without a finished message");

    // The queue is empty after reset, so input is taken at once.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind halfsiphash_2_4_32bit_unit hsh_checker u_hsh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);

### tb/sv/halfsiphash_2_4_32bit_unit_tb.sv
// Self-checking testbench that streams keyed messages into the HalfSipHash unit and checks each hash.
module halfsiphash_2_4_32bit_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsh_pkg::*;

    // Round counts of the standard 2-4 variant; the unit is built with the same values.
    localparam int HASH_COMPRESS_ROUNDS = 2;
    localparam int HASH_FINAL_ROUNDS    = 4;

    // The slowest word is a four-byte last word and the command queue holds two more,
    // so the quiet stretch after the last hash is plenty for the unit to settle.
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS_PER_KEY = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_LOW;
    logic [WORD_W-1:0]    cfg_write_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_message_word = '0;
    logic [CNT_W-1:0]     s_byte_count = '0;
    logic                 s_last_word = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WORD_W-1:0]    m_hash_value;

    // Predictor state: the key as last written, and the chaining words, the
    // running length byte and the open-message flag of the message in flight.
    hsh_word_t   key_word_low = '0;
    hsh_word_t   key_word_high = '0;
    hsh_word_t   hash_chain [0:3];
    logic [LEN_W-1:0] msg_len = '0;
    bit          msg_open = 1'b0;

    // Hashes that the unit still owes us, oldest first.
    hsh_word_t   expected_hashes [$];
    hsh_word_t   want_hash;

    int errors = 0;
    int hashes_checked = 0;
    int words_sent = 0;
    int messages_sent = 0;
    int key_settings = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int ready_tick = 0;
    bit steady = 1'b0;

    halfsiphash_2_4_32bit_unit #(
        .COMPRESS_ROUNDS(HASH_COMPRESS_ROUNDS),
        .FINAL_ROUNDS   (HASH_FINAL_ROUNDS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_write_data(cfg_write_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_message_word(s_message_word),
        .s_byte_count  (s_byte_count),
        .s_last_word   (s_last_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_value  (m_hash_value)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d hashes still owed", $realtime,
                     cycle_count, expected_hashes.size());
            $display("halfsiphash_2_4_32bit_unit_tb: done, errors");
            $finish;
        end
    end

    // The result side stalls on its own pattern. As bits 9:8 of its tick counter
    // advance it moves to the next mode: always ready, mostly ready, rarely
    // ready, and a fixed pattern that is ready only when the low four tick bits are zero.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        case (ready_tick[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (ready_tick[3:0] == 4'd0);
        endcase
    end

    // Each hash word taken from the unit is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hashes.size() == 0) begin
                errors++;
                $display("%0t: hash %h arrived with none expected", $realtime, m_hash_value);
            end else begin
                want_hash = expected_hashes.pop_front();
                hashes_checked++;
                if (m_hash_value !== want_hash) begin
                    errors++;
                    $display("%0t: hash_value expected %h actual %h", $realtime, want_hash,
                             m_hash_value);
                end
            end
        end
    end

    function automatic hsh_word_t rot_left(input hsh_word_t x, input int r);
        logic [2*WORD_W-1:0] twice;
        twice = {x, x} << r;
        return twice[2*WORD_W-1:WORD_W];
    endfunction

    // One add-rotate-xor round over the chaining words.
    task automatic sip_round();
        hsh_word_t a;
        hsh_word_t b;
        hsh_word_t c;
        hsh_word_t d;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        a = a + b;
        b = rot_left(b, 5) ^ a;
        a = rot_left(a, 16);
        c = c + d;
        d = rot_left(d, 8) ^ c;
        a = a + d;
        d = rot_left(d, 7) ^ a;
        c = c + b;
        b = rot_left(b, 13) ^ c;
        c = rot_left(c, 16);
        hash_chain[0] = a;
        hash_chain[1] = b;
        hash_chain[2] = c;
        hash_chain[3] = d;
    endtask

    task automatic absorb_block(input hsh_word_t blk);
        hash_chain[3] ^= blk;
        repeat (HASH_COMPRESS_ROUNDS) sip_round();
        hash_chain[0] ^= blk;
    endtask

    // Advances the predicted hash state by one accepted word and queues the
    // hash when the word closes its message.
    task automatic predict_hash(input hsh_word_t word, input logic [CNT_W-1:0] count,
                                input bit last);
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] tail;
        hsh_word_t        final_blk;
        // Counts above four mean a full word.
        n = (count > FULL_COUNT) ? FULL_COUNT : count;
        if (!msg_open) begin
            hash_chain[0] = key_word_low;
            hash_chain[1] = key_word_high;
            hash_chain[2] = key_word_low ^ INIT_C2;
            hash_chain[3] = key_word_high ^ INIT_C3;
            msg_len = '0;
            msg_open = 1'b1;
        end
        if (!last) begin
            // The count of an inner word does not matter; all four bytes go in.
            absorb_block(word);
            msg_len = msg_len + LEN_W'(FULL_COUNT);
        end else begin
            tail = n;
            if (n == FULL_COUNT) begin
                absorb_block(word);
                tail = '0;
            end
            msg_len = msg_len + LEN_W'(n);
            // Length byte on top, leftover bytes below, unused bytes dropped.
            final_blk = hsh_word_t'(msg_len) << LEN_SHIFT;
            final_blk |= word & ~({WORD_W{1'b1}} << (8 * tail));
            absorb_block(final_blk);
            hash_chain[2] ^= hsh_word_t'(FINAL_XOR);
            repeat (HASH_FINAL_ROUNDS) sip_round();
            expected_hashes.push_back(hash_chain[1] ^ hash_chain[3]);
            msg_open = 1'b0;
            messages_sent++;
        end
    endtask

    // Offers one word and returns at the edge that accepts it. Words go out in
    // bursts; between bursts valid may drop for a random number of cycles unless
    // the current stretch is meant to run without gaps.
    task automatic send_word(input hsh_word_t word, input logic [CNT_W-1:0] count,
                             input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_message_word <= word;
        s_byte_count   <= count;
        s_last_word    <= last;
        do @(posedge aclk); while (!s_ready);
        predict_hash(word, count, last);
        words_sent++;
    endtask

    // Holds off the sender until every owed hash has come and the unit has had
    // time to finish any word that produces no hash.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both key registers on back-to-back edges; call only when idle.
    task automatic write_key(input hsh_word_t lo, input hsh_word_t hi);
        cfg_write_en   <= 1'b1;
        cfg_index      <= CFG_KEY_LOW;
        cfg_write_data <= lo;
        @(posedge aclk);
        cfg_index      <= CFG_KEY_HIGH;
        cfg_write_data <= hi;
        @(posedge aclk);
        cfg_write_en   <= 1'b0;
        key_word_low  = lo;
        key_word_high = hi;
        key_settings++;
    endtask

    // Single-word messages of every length under the all-zero reset key,
    // including the empty message; the short ones carry ones in unused bytes.
    task automatic test_short_messages();
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'h0302_0100, 3'd4, 1'b1);
        wait_idle();
    endtask

    // Counts of five to seven on a last word, and short counts on inner words.
    task automatic test_odd_counts();
        write_key(32'h0302_0100, 32'h0706_0504);
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'h9abc_def0, 3'd6, 1'b1);
        send_word(32'h0f1e_2d3c, 3'd7, 1'b1);
        send_word(32'hdead_beef, 3'd0, 1'b0);
        send_word(32'hcafe_f00d, 3'd2, 1'b0);
        send_word(32'h5555_aaaa, 3'd3, 1'b1);
        wait_idle();
    endtask

    // All-zero and all-one words under the all-one key.
    task automatic test_word_extremes();
        write_key(32'hffff_ffff, 32'hffff_ffff);
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h0000_0000, 3'd0, 1'b1);
        wait_idle();
    endtask

    // A key written while a message is open must only apply to the next one.
    task automatic test_key_change_mid_message();
        write_key(32'h0000_0000, 32'hffff_ffff);
        send_word(32'h0123_4567, 3'd4, 1'b0);
        wait_idle();
        write_key(32'hffff_ffff, 32'h0000_0000);
        send_word(32'h89ab_cdef, 3'd2, 1'b1);
        send_word(32'h89ab_cdef, 3'd2, 1'b1);
        wait_idle();
    endtask

    // One random message: mostly short, sometimes empty, now and then long
    // enough that the length byte wraps. Inner words usually carry four bytes.
    task automatic send_random_message();
        int kind;
        int inner_words;
        logic [CNT_W-1:0] cnt;
        kind = $urandom_range(0, 99);
        if (kind < 3)
            inner_words = $urandom_range(64, 70);
        else if (kind < 15)
            inner_words = 0;
        else
            inner_words = $urandom_range(1, 6);
        for (int i = 0; i < inner_words; i++) begin
            cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 7)) : FULL_COUNT;
            send_word($urandom, cnt, 1'b0);
        end
        cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(5, 7))
                                          : CNT_W'($urandom_range(0, 4));
        send_word($urandom, cnt, 1'b1);
    endtask

    // Random traffic under a series of keys, the extremes among them. Every
    // other key runs its traffic with no sender gaps.
    task automatic test_random_messages();
        hsh_word_t key_lo [6];
        hsh_word_t key_hi [6];
        int        target;
        key_lo = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h0000_0000, 32'hffff_ffff,
                   $urandom};
        key_hi = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'hffff_ffff, 32'h0000_0000,
                   $urandom};
        for (int k = 0; k < 6; k++) begin
            write_key(key_lo[k], key_hi[k]);
            steady = k[0];
            target = words_sent + RANDOM_WORDS_PER_KEY;
            while (words_sent < target) send_random_message();
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 4; i++) hash_chain[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_messages();
        test_odd_counts();
        test_word_extremes();
        test_key_change_mid_message();
        test_random_messages();

        // wait_idle already drained the unit; anything still owed is a miss.
        if (expected_hashes.size() != 0) begin
            errors += expected_hashes.size();
            $display("%0t: %0d hashes never arrived", $realtime, expected_hashes.size());
        end

        $display("Run covered %0d words in %0d messages under %0d keys.", words_sent,
                 messages_sent, key_settings);
        $display("%0d hashes compared, %0d mismatches or misses.", hashes_checked, errors);
        if (errors == 0)
            $display("halfsiphash_2_4_32bit_unit_tb: done, clean");
        else
            $display("halfsiphash_2_4_32bit_unit_tb: done, errors");
        $finish;
    end

endmodule
